// ----- src/wdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wdf_pkg - shared types for the WebSocket frame deframer
// Parser phase codes and the result record passed to the output buffer.
// ----------------------------------------------------------------------------
package wdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CountW  = 3;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_SKIP  = 3'd4,
    PH_KEY   = 3'd5,
    PH_DATA  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [OpW-1:0]   frame_opcode;
    logic             has_data;
    logic             last;
    logic             error;
  } result_t;

endpackage

// ----- src/wdf_parser.sv -----
// ----------------------------------------------------------------------------
// wdf_parser - frame header parser and payload unmasker
// Holds the per-frame state; each accepted byte updates it and may
// produce one result, presented combinationally.
// ----------------------------------------------------------------------------
module wdf_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  output logic                  res_valid,
  output wdf_pkg::result_t      res
);
  import wdf_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [OpW-1:0]    opcode_r, opcode_nxt;
  logic              mask_r, mask_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [KeyW-1:0]   key_r, key_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              halted_r, halted_nxt;

  logic [6:0]        code;
  logic [LenW-1:0]   len_dec;
  logic [CountW-1:0] count_inc;
  logic [ByteW-1:0]  key_byte;

  assign code      = in_byte[6:0];
  assign len_dec   = len_r - LenW'(1);
  assign count_inc = count_r + CountW'(1);

  always_comb begin
    case (count_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    if (!halted_r) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_nxt = in_byte[7];
          if (code == LenCode16) begin
            phase_nxt = PH_LENHI;
          end else if (code == LenCode64) begin
            count_nxt = '0;
            phase_nxt = PH_SKIP;
          end else begin
            len_nxt = LenW'(code);
            if (in_byte[7]) begin
              count_nxt = '0;
              key_nxt   = '0;
              phase_nxt = PH_KEY;
            end else begin
              count_nxt = '0;
              phase_nxt = (code == 7'd0) ? PH_HDR0 : PH_DATA;
            end
          end
        end
        PH_LENHI: begin
          len_nxt   = {in_byte, 8'h00};
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_nxt   = {len_r[15:8], in_byte};
          count_nxt = '0;
          if (mask_r) begin
            key_nxt   = '0;
            phase_nxt = PH_KEY;
          end else begin
            phase_nxt = ({len_r[15:8], in_byte} == '0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_SKIP: begin
          count_nxt = count_inc;
          if (count_inc == '0) begin
            halted_nxt = 1'b1;
            phase_nxt  = PH_HDR0;
          end
        end
        PH_KEY: begin
          key_nxt   = {key_r[23:0], in_byte};
          count_nxt = count_inc;
          if (count_inc >= CountW'(4)) begin
            count_nxt = '0;
            phase_nxt = (len_r == '0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_DATA: begin
          count_nxt = {1'b0, count_r[1:0] + 2'd1};
          len_nxt   = len_dec;
          if (len_dec == '0) phase_nxt = PH_HDR0;
        end
        default: begin
          opcode_nxt = in_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid        = 1'b0;
    res.data_byte    = '0;
    res.frame_opcode = opcode_r;
    res.has_data     = 1'b0;
    res.last         = 1'b0;
    res.error        = 1'b0;
    if (take && !halted_r) begin
      unique case (phase_r)
        PH_HDR1: begin
          if (code != LenCode16 && code != LenCode64 && !in_byte[7] && code == 7'd0) begin
            res_valid = 1'b1;
            res.last  = 1'b1;
          end
        end
        PH_LENLO: begin
          if (!mask_r && {len_r[15:8], in_byte} == '0) begin
            res_valid = 1'b1;
            res.last  = 1'b1;
          end
        end
        PH_SKIP: begin
          if (count_inc == '0) begin
            res_valid = 1'b1;
            res.error = 1'b1;
          end
        end
        PH_KEY: begin
          if (count_inc >= CountW'(4) && len_r == '0) begin
            res_valid = 1'b1;
            res.last  = 1'b1;
          end
        end
        PH_DATA: begin
          res_valid     = 1'b1;
          res.has_data  = 1'b1;
          res.data_byte = mask_r ? (in_byte ^ key_byte) : in_byte;
          res.last      = (len_dec == '0);
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ----- src/wdf_obuf.sv -----
// ----------------------------------------------------------------------------
// wdf_obuf - result register with skid stage
// Two-entry buffer; upstream stall is driven from a register only.
// ----------------------------------------------------------------------------
module wdf_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wdf_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output wdf_pkg::result_t out_data
);
  import wdf_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t skid_d_r, skid_d_nxt;

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || !out_stall) begin
      out_v_nxt  = skid_v_r || push;
      out_d_nxt  = skid_v_r ? skid_d_r : push_data;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

// ----- src/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer - WebSocket receive-side frame parser
// Input: one stream byte per transaction (in_valid / in_stall / in_byte).
// Output: one result per payload byte (unmasked data, opcode, last marker),
// one marker per empty frame, and one error result once the eight length
// bytes after a 64-bit length code are skipped; the block then ignores
// all input until reset. Other header bytes produce no result.
// Throughput: one byte per clock cycle while in_stall is low. Each
// result is registered before it appears on the out_ port.
// The parser state updates once per accepted byte; results go through a
// result register backed by a skid stage, so out_stall reaches in_stall
// only through a register: in_stall rises in the cycle after a stalled
// result is followed by another, and no result is lost.
// Reset (rst_n low, synchronous) returns the parser to awaiting the first
// header byte, clears the halt and empties both result stages.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_frame_opcode,
  output logic       out_has_data,
  output logic       out_last,
  output logic       out_error
);
  import wdf_pkg::*;

  logic    take;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t out_res;

  assign in_stall = full;
  assign take     = in_valid && !full;

  wdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wdf_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_data_byte    = out_res.data_byte;
  assign out_frame_opcode = out_res.frame_opcode;
  assign out_has_data     = out_res.has_data;
  assign out_last         = out_res.last;
  assign out_error        = out_res.error;

endmodule
